### hdl/fpth_pkg.sv
// Shared types and constants for the force/pose tare and heading block.
package fpth_pkg;

  // Channel count and field widths
  localparam int NCH    = 9;
  localparam int SMP_W  = 24;
  localparam int SUM_W  = 28;
  localparam int CNT_W  = 4;
  localparam int Q_W    = 16;
  localparam int PROD_W = 32;
  localparam int HEAD_W = 16;

  typedef logic signed [SMP_W-1:0]  smp_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [Q_W-1:0]    quat_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [HEAD_W-1:0] head_t;

  // Saturation limits of a delta channel
  localparam smp_t SMP_MAX = 24'sh7FFFFF;
  localparam smp_t SMP_MIN = 24'sh800000;

  // Item opcodes
  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_REARM  = 1'b1
  } op_t;

  // Quaternion products held in the input register
  typedef struct packed {
    prod_t xz;
    prod_t wy;
    prod_t yz;
    prod_t wx;
    prod_t xx;
    prod_t yy;
  } prod_set_t;

  // Status of the offset divider
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### hdl/fpth_div.sv
// Offset unit: rounded division of the nine reference sums by the sample count.
module fpth_div import fpth_pkg::*; #(
  parameter int unsigned REF_SAMPLES = 10
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  sum_t      sums [NCH],
  output smp_t      offs [NCH],
  output div_stat_t stat
);

  // Reciprocal with 31 fraction bits: exact floor for magnitudes below 2^27
  localparam int unsigned RK = 31;
  localparam logic [31:0] RECIP =
    32'(((64'd1 << RK) + 64'(REF_SAMPLES) - 64'd1) / 64'(REF_SAMPLES));
  localparam logic [SUM_W-1:0] HALF = SUM_W'(REF_SAMPLES / 2);
  localparam int MUL_W = SUM_W + 32;

  logic                 rnd_r;
  logic                 mul_r;
  logic [NCH-1:0]       neg_r;
  logic [SUM_W-1:0]     mag_r   [NCH];
  logic [SUM_W-1:0]     mag_nxt [NCH];
  logic [MUL_W-1:0]     prod    [NCH];
  logic [SMP_W:0]       quo     [NCH];
  logic [SMP_W:0]       quo_neg [NCH];
  smp_t                 offs_r  [NCH];
  smp_t                 offs_nxt[NCH];

  // Sequence: magnitude and rounding bias step (rnd_r), then the multiply step (mul_r)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rnd_r <= 1'b0;
      mul_r <= 1'b0;
    end else begin
      rnd_r <= start;
      mul_r <= rnd_r;
    end
  end

  // Take magnitude and add half the divisor (ties away from zero)
  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      mag_nxt[i] = (sums[i][SUM_W-1] ? SUM_W'(-sums[i]) : SUM_W'(sums[i])) + HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (rnd_r) begin
      for (int i = 0; i < NCH; i++) begin
        neg_r[i] <= sums[i][SUM_W-1];
        mag_r[i] <= mag_nxt[i];
      end
    end
  end

  // Multiply by the reciprocal, restore the sign
  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      prod[i]     = MUL_W'(mag_r[i]) * MUL_W'(RECIP);
      quo[i]      = prod[i][RK+SMP_W:RK];
      quo_neg[i]  = -quo[i];
      offs_nxt[i] = neg_r[i] ? smp_t'(quo_neg[i][SMP_W-1:0]) : smp_t'(quo[i][SMP_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (mul_r) begin
      for (int i = 0; i < NCH; i++) begin
        offs_r[i] <= offs_nxt[i];
      end
    end
  end

  assign offs      = offs_r;
  assign stat.busy = rnd_r | mul_r;
  assign stat.done = mul_r;

endmodule

### hdl/fpth_head.sv
// Heading: rotated z axis from registered quaternion products, rounded and saturated.
module fpth_head import fpth_pkg::*; (
  input  prod_set_t prods,
  output head_t     hx,
  output head_t     hy,
  output head_t     hz
);

  localparam int ACC_W = PROD_W + 2;
  localparam logic signed [ACC_W-1:0] ONE_Q28  = ACC_W'(64'sd1 <<< 27);
  localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(64'sd4096);
  localparam logic signed [ACC_W-1:0] H_MAX    = ACC_W'(64'sd32767);
  localparam logic signed [ACC_W-1:0] H_MIN    = -ACC_W'(64'sd32768);

  logic signed [ACC_W-1:0] acc_x;
  logic signed [ACC_W-1:0] acc_y;
  logic signed [ACC_W-1:0] acc_z;

  // Round the Q2.28 sum, doubled, to Q1.14, ties toward +inf, then clamp to 16 bits
  function automatic head_t rnd_sat(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    r = (v + RND_BIAS) >>> 13;
    if (r > H_MAX) begin
      return head_t'(H_MAX[HEAD_W-1:0]);
    end else if (r < H_MIN) begin
      return head_t'(H_MIN[HEAD_W-1:0]);
    end
    return head_t'(r[HEAD_W-1:0]);
  endfunction

  // Combine products
  assign acc_x = ACC_W'(prods.xz) + ACC_W'(prods.wy);
  assign acc_y = ACC_W'(prods.yz) - ACC_W'(prods.wx);
  assign acc_z = ONE_Q28 - (ACC_W'(prods.xx) + ACC_W'(prods.yy));

  assign hx = rnd_sat(acc_x);
  assign hy = rnd_sat(acc_y);
  assign hz = rnd_sat(acc_z);

endmodule

### hdl/force_pose_tare_and_heading.sv
// Top level: force/pose tare with reference averaging and heading output.
//
// Input channel (in_valid/in_ready) carries either a sample pair (opcode 0:
// nine 24-bit force, torque and position values plus a packed Q1.14
// quaternion) or a rearm (opcode 1). A rearm clears the reference sums and
// starts collection; the next REF_SAMPLES samples are summed and averaged
// into nine offsets. Samples after that each give one result item on the
// output channel (out_valid/out_ready): tared deltas saturated to 24 bits
// and the rotated z axis in Q1.14. Idle, collecting and rearm items give no
// result.
// An accepted item is registered in the input register, and its result is
// then registered in the output register.
// Throughput: one item per cycle. After the last reference sample the input
// register holds while the offset divider (one multiply per channel) runs.
// When the receiver stalls, the output register holds its item and the
// input register still takes one more item before in_ready drops.
// Synchronous reset clears the valid flags and the tare state; no offsets
// are in use until a collection completes.
module force_pose_tare_and_heading import fpth_pkg::*; #(
  parameter int unsigned REF_SAMPLES = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [0:0]          in_opcode,
  input  logic signed [23:0]  in_force_x,
  input  logic signed [23:0]  in_force_y,
  input  logic signed [23:0]  in_force_z,
  input  logic signed [23:0]  in_torque_x,
  input  logic signed [23:0]  in_torque_y,
  input  logic signed [23:0]  in_torque_z,
  input  logic signed [23:0]  in_pos_x,
  input  logic signed [23:0]  in_pos_y,
  input  logic signed [23:0]  in_pos_z,
  input  logic [63:0]         in_orientation_packed,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [23:0]  out_delta_force_x,
  output logic signed [23:0]  out_delta_force_y,
  output logic signed [23:0]  out_delta_force_z,
  output logic signed [23:0]  out_delta_torque_x,
  output logic signed [23:0]  out_delta_torque_y,
  output logic signed [23:0]  out_delta_torque_z,
  output logic signed [23:0]  out_delta_pos_x,
  output logic signed [23:0]  out_delta_pos_y,
  output logic signed [23:0]  out_delta_pos_z,
  output logic signed [15:0]  out_heading_x,
  output logic signed [15:0]  out_heading_y,
  output logic signed [15:0]  out_heading_z
);

  smp_t             in_smp [NCH];
  quat_t            qw, qx, qy, qz;
  prod_set_t        prod_nxt;

  logic             s1_valid_r;
  op_t              s1_op_r;
  smp_t             s1_smp_r [NCH];
  prod_set_t        s1_prod_r;
  logic             s1_res;
  logic             s1_adv;
  logic             in_take;

  logic             collecting_r, collecting_nxt;
  logic             recording_r, recording_nxt;
  logic [CNT_W-1:0] count_r, count_nxt, count_inc;
  logic             last_smp;
  logic             div_start;
  sum_t             sums_r   [NCH];
  sum_t             sums_nxt [NCH];
  smp_t             offs     [NCH];
  div_stat_t        div_stat;

  logic             out_valid_r;
  smp_t             out_dlt_r [NCH];
  smp_t             dlt_nxt   [NCH];
  head_t            hx_nxt, hy_nxt, hz_nxt;
  head_t            hx_r, hy_r, hz_r;

  // Difference of two 24-bit values, clamped to 24 bits
  function automatic smp_t sat_sub(input smp_t a, input smp_t b);
    logic signed [SMP_W:0] d;
    d = (SMP_W+1)'(a) - (SMP_W+1)'(b);
    if (d[SMP_W] != d[SMP_W-1]) begin
      return d[SMP_W] ? SMP_MIN : SMP_MAX;
    end
    return smp_t'(d[SMP_W-1:0]);
  endfunction

  // Gather the sample channels in fixed order
  assign in_smp[0] = in_force_x;
  assign in_smp[1] = in_force_y;
  assign in_smp[2] = in_force_z;
  assign in_smp[3] = in_torque_x;
  assign in_smp[4] = in_torque_y;
  assign in_smp[5] = in_torque_z;
  assign in_smp[6] = in_pos_x;
  assign in_smp[7] = in_pos_y;
  assign in_smp[8] = in_pos_z;

  // Unpack the quaternion and form the products ahead of the input register
  assign qw = in_orientation_packed[63:48];
  assign qx = in_orientation_packed[47:32];
  assign qy = in_orientation_packed[31:16];
  assign qz = in_orientation_packed[15:0];

  assign prod_nxt.xz = PROD_W'(qx) * PROD_W'(qz);
  assign prod_nxt.wy = PROD_W'(qw) * PROD_W'(qy);
  assign prod_nxt.yz = PROD_W'(qy) * PROD_W'(qz);
  assign prod_nxt.wx = PROD_W'(qw) * PROD_W'(qx);
  assign prod_nxt.xx = PROD_W'(qx) * PROD_W'(qx);
  assign prod_nxt.yy = PROD_W'(qy) * PROD_W'(qy);

  // Handshake: the input register advances unless a result is blocked or offsets are pending
  assign s1_res   = (s1_op_r == OP_SAMPLE) && !collecting_r && recording_r;
  assign s1_adv   = s1_valid_r && !div_stat.busy && (!s1_res || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_take  = in_valid && in_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r   <= op_t'(in_opcode);
      s1_smp_r  <= in_smp;
      s1_prod_r <= prod_nxt;
    end
  end

  // Tare state: rearm, accumulate reference, finish collection
  assign count_inc = count_r + CNT_W'(1);
  assign last_smp  = (count_inc == CNT_W'(REF_SAMPLES));

  always_comb begin
    collecting_nxt = collecting_r;
    recording_nxt  = recording_r;
    count_nxt      = count_r;
    div_start      = 1'b0;
    sums_nxt       = sums_r;
    if (s1_adv) begin
      unique case (s1_op_r)
        OP_REARM: begin
          collecting_nxt = 1'b1;
          recording_nxt  = 1'b0;
          count_nxt      = '0;
          for (int i = 0; i < NCH; i++) begin
            sums_nxt[i] = '0;
          end
        end
        OP_SAMPLE: begin
          if (collecting_r) begin
            count_nxt = count_inc;
            for (int i = 0; i < NCH; i++) begin
              sums_nxt[i] = sums_r[i] + SUM_W'(s1_smp_r[i]);
            end
            if (last_smp) begin
              collecting_nxt = 1'b0;
              recording_nxt  = 1'b1;
              div_start      = 1'b1;
            end
          end
        end
        default: begin
          collecting_nxt = collecting_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      collecting_r <= 1'b0;
      recording_r  <= 1'b0;
      count_r      <= '0;
    end else begin
      collecting_r <= collecting_nxt;
      recording_r  <= recording_nxt;
      count_r      <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sums_r <= sums_nxt;
  end

  // Offset divider
  fpth_div #(
    .REF_SAMPLES (REF_SAMPLES)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .sums  (sums_r),
    .offs  (offs),
    .stat  (div_stat)
  );

  // Heading from registered products
  fpth_head u_head (
    .prods (s1_prod_r),
    .hx    (hx_nxt),
    .hy    (hy_nxt),
    .hz    (hz_nxt)
  );

  // Tared deltas
  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      dlt_nxt[i] = sat_sub(s1_smp_r[i], offs[i]);
    end
  end

  // Output register: load on a result, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_res) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_res) begin
      out_dlt_r <= dlt_nxt;
      hx_r      <= hx_nxt;
      hy_r      <= hy_nxt;
      hz_r      <= hz_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_delta_force_x  = out_dlt_r[0];
  assign out_delta_force_y  = out_dlt_r[1];
  assign out_delta_force_z  = out_dlt_r[2];
  assign out_delta_torque_x = out_dlt_r[3];
  assign out_delta_torque_y = out_dlt_r[4];
  assign out_delta_torque_z = out_dlt_r[5];
  assign out_delta_pos_x    = out_dlt_r[6];
  assign out_delta_pos_y    = out_dlt_r[7];
  assign out_delta_pos_z    = out_dlt_r[8];
  assign out_heading_x      = hx_r;
  assign out_heading_y      = hy_r;
  assign out_heading_z      = hz_r;

  // Checks
  a_hold_while_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> !s1_adv)
    else $error("input register advanced while offsets were being computed");

  a_mode_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(collecting_r && recording_r))
    else $error("collecting and recording both set");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    collecting_r |-> (count_r < CNT_W'(REF_SAMPLES)))
    else $error("reference count overran while collecting");

  a_div_done_mode: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (recording_r && !collecting_r))
    else $error("offsets latched outside of recording");

  a_result_recording: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(recording_r))
    else $error("result produced while not recording");

endmodule
